[rtl/bks_pkg.sv]
package bks_pkg;

  localparam int unsigned CordIter  = 20;
  localparam int unsigned DivSteps  = 47;
  localparam logic [33:0] CordGain  = 34'd652032874;
  localparam logic [33:0] AngPerRad = 34'd683565276;

  typedef enum logic [21:0] {
    S_IDLE  = 22'd1,
    S_CORD1 = 22'd2,
    S_MX1   = 22'd4,
    S_MX2   = 22'd8,
    S_MY1   = 22'd16,
    S_MY2   = 22'd32,
    S_ACC   = 22'd64,
    S_SPD   = 22'd128,
    S_CORD2 = 22'd256,
    S_TLOAD = 22'd512,
    S_TDIV  = 22'd1024,
    S_VTLO  = 22'd2048,
    S_VTHI  = 22'd4096,
    S_QLOAD = 22'd8192,
    S_QDIV  = 22'd16384,
    S_RLO   = 22'd32768,
    S_RHI   = 22'd65536,
    S_RSUM  = 22'd131072,
    S_KLO   = 22'd262144,
    S_KHI   = 22'd524288,
    S_TURN  = 22'd1048576,
    S_DONE  = 22'd2097152
  } state_e;

  typedef enum logic [1:0] {
    REG_WHEELBASE = 2'd0,
    REG_STEER_LIM = 2'd1,
    REG_SPD_FLOOR = 2'd2,
    REG_SPD_CEIL  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ACT_STEP = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] val;
    case (idx)
      5'd0:    val = 22'd2097152;
      5'd1:    val = 22'd1238021;
      5'd2:    val = 22'd654136;
      5'd3:    val = 22'd332050;
      5'd4:    val = 22'd166669;
      5'd5:    val = 22'd83415;
      5'd6:    val = 22'd41718;
      5'd7:    val = 22'd20860;
      5'd8:    val = 22'd10430;
      5'd9:    val = 22'd5215;
      5'd10:   val = 22'd2608;
      5'd11:   val = 22'd1304;
      5'd12:   val = 22'd652;
      5'd13:   val = 22'd326;
      5'd14:   val = 22'd163;
      5'd15:   val = 22'd81;
      5'd16:   val = 22'd41;
      5'd17:   val = 22'd20;
      5'd18:   val = 22'd10;
      5'd19:   val = 22'd5;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

[rtl/bicycle_kinematic_step_top.sv]
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  action, accel, steer, time_step, load_*
// out       output     out_valid_o/out_stall_i pos_x, pos_y, heading, speed
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load item goes from acceptance straight to the done state and the output register
// a step item runs two 20-step cordic passes and two 47-step restoring divides
// on the shared divider, plus eleven multiplies on one 34x34 multiplier; the
// second divide is skipped when the turn rate saturates; in_stall_o is high
// for the whole item
// reset returns the pose, speed and registers to their reset values at once
// out_stall_i holds the finished item in the output register; the next item
// is accepted meanwhile and waits at its end until the register frees
module bicycle_kinematic_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] accel_i,
  input  logic [15:0] steer_i,
  input  logic [15:0] time_step_i,
  input  logic [31:0] load_x_i,
  input  logic [31:0] load_y_i,
  input  logic [15:0] load_heading_i,
  input  logic [31:0] load_speed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [15:0] heading_o,
  output logic [31:0] speed_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  bks_pkg::state_e state_q, state_d;

  logic [30:0] wb_q;
  logic [13:0] lim_q;
  logic signed [31:0] floor_q, ceil_q;

  logic signed [31:0] cur_x_q, cur_y_q, cur_spd_q, nv_q;
  logic [15:0] cur_hd_q;

  logic signed [31:0] accel_q;
  logic signed [15:0] st_q;
  logic [15:0] dt_q;

  logic [5:0] cnt_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic flip_q;

  logic [31:0] rem_q, div_q;
  logic [46:0] num_q;
  logic [63:0] acc_q;
  logic [62:0] r_q;
  logic signed [67:0] prod_q;

  logic out_valid_q;
  logic signed [31:0] o_x_q, o_y_q, o_spd_q;
  logic [15:0] o_hd_q;

  logic signed [33:0] mul_a, mul_b;

  // steer clamp
  logic signed [15:0] st_in, lim_s, st_clamp;
  // cordic load
  logic signed [16:0] ang_s, ang_f;
  logic ang_flip;
  // cordic step
  logic signed [33:0] xs, ys, c_val, s_val, s_abs;
  logic signed [25:0] atan_s;
  // divider step
  logic [32:0] rsh;
  logic rge;
  // datapath helpers
  logic signed [33:0] t_val, dacc, nv34, flr34, cl34;
  logic signed [35:0] dpos, psum;
  logic signed [31:0] psat;
  logic signed [31:0] pos_cur;
  logic [31:0] vm, wb_eff, sum32;
  logic [77:0] numw;
  logic [15:0] turn;
  logic neg;

  assign in_stall_o  = (state_q != bks_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = o_x_q;
  assign pos_y_o     = o_y_q;
  assign heading_o   = o_hd_q;
  assign speed_o     = o_spd_q;

  always_comb begin
    st_in = signed'(steer_i);
    lim_s = signed'({2'b00, lim_q});
    if (st_in > lim_s) begin
      st_clamp = lim_s;
    end else if (st_in < -lim_s) begin
      st_clamp = -lim_s;
    end else begin
      st_clamp = st_in;
    end
  end

  always_comb begin
    if (state_q == bks_pkg::S_IDLE) begin
      ang_s = 17'(signed'(cur_hd_q));
    end else begin
      ang_s = 17'(st_q);
    end
    ang_flip = 1'b0;
    ang_f    = ang_s;
    if (ang_s > 17'sd16384) begin
      ang_f    = ang_s - 17'sd32768;
      ang_flip = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      ang_f    = ang_s + 17'sd32768;
      ang_flip = 1'b1;
    end
  end

  always_comb begin
    xs     = cx_q >>> cnt_q[4:0];
    ys     = cy_q >>> cnt_q[4:0];
    atan_s = signed'({4'b0000, bks_pkg::atan_lut(cnt_q[4:0])});
    c_val  = flip_q ? -cx_q : cx_q;
    s_val  = flip_q ? -cy_q : cy_q;
    s_abs  = s_val[33] ? -s_val : s_val;
  end

  always_comb begin
    rsh = {rem_q, num_q[46]};
    rge = (rsh >= {1'b0, div_q});
  end

  always_comb begin
    t_val   = prod_q[63:30];
    dpos    = prod_q[51:16];
    pos_cur = (state_q == bks_pkg::S_MY1) ? cur_x_q : cur_y_q;
    psum    = 36'(pos_cur) + dpos;
    if (psum > 36'sd2147483647) begin
      psat = 32'sh7fffffff;
    end else if (psum < -36'sd2147483648) begin
      psat = 32'sh80000000;
    end else begin
      psat = psum[31:0];
    end
    dacc  = prod_q[49:16];
    flr34 = 34'(floor_q);
    cl34  = 34'(ceil_q);
    nv34  = 34'(cur_spd_q) + dacc;
    if (nv34 < flr34) begin
      nv34 = flr34;
    end
    if (nv34 > cl34) begin
      nv34 = cl34;
    end
    vm     = cur_spd_q[31] ? 32'(-cur_spd_q) : 32'(cur_spd_q);
    wb_eff = (wb_q == 31'd0) ? 32'd1 : {1'b0, wb_q};
    numw   = {14'd0, acc_q} + {prod_q[45:0], 32'd0};
    sum32  = prod_q[31:0] + {2'b00, acc_q[61:32]};
    turn   = sum32[31:16];
    neg    = (cur_spd_q != 32'sd0) && (st_q != 16'sd0) && (cur_spd_q[31] != st_q[15]);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      bks_pkg::S_MX1: begin
        mul_a = 34'(cur_spd_q);
        mul_b = c_val;
      end
      bks_pkg::S_MY1: begin
        mul_a = 34'(cur_spd_q);
        mul_b = s_val;
      end
      bks_pkg::S_MX2, bks_pkg::S_MY2: begin
        mul_a = t_val;
        mul_b = signed'({18'd0, dt_q});
      end
      bks_pkg::S_ACC: begin
        mul_a = 34'(accel_q);
        mul_b = signed'({18'd0, dt_q});
      end
      bks_pkg::S_VTLO: begin
        mul_a = signed'({2'b00, vm});
        mul_b = signed'({2'b00, num_q[31:0]});
      end
      bks_pkg::S_VTHI: begin
        mul_a = signed'({2'b00, vm});
        mul_b = signed'({19'd0, num_q[46:32]});
      end
      bks_pkg::S_RLO: begin
        mul_a = signed'({2'b00, num_q[31:0]});
        mul_b = signed'({18'd0, dt_q});
      end
      bks_pkg::S_RHI: begin
        mul_a = signed'({19'd0, num_q[46:32]});
        mul_b = signed'({18'd0, dt_q});
      end
      bks_pkg::S_KLO: begin
        mul_a = signed'({2'b00, r_q[31:0]});
        mul_b = signed'(bks_pkg::AngPerRad);
      end
      bks_pkg::S_KHI: begin
        mul_a = signed'({3'b000, r_q[62:32]});
        mul_b = signed'(bks_pkg::AngPerRad);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bks_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (action_i == bks_pkg::ACT_LOAD) ? bks_pkg::S_DONE : bks_pkg::S_CORD1;
        end
      end
      bks_pkg::S_CORD1: begin
        if (cnt_q == 6'(bks_pkg::CordIter - 1)) state_d = bks_pkg::S_MX1;
      end
      bks_pkg::S_MX1:   state_d = bks_pkg::S_MX2;
      bks_pkg::S_MX2:   state_d = bks_pkg::S_MY1;
      bks_pkg::S_MY1:   state_d = bks_pkg::S_MY2;
      bks_pkg::S_MY2:   state_d = bks_pkg::S_ACC;
      bks_pkg::S_ACC:   state_d = bks_pkg::S_SPD;
      bks_pkg::S_SPD:   state_d = bks_pkg::S_CORD2;
      bks_pkg::S_CORD2: begin
        if (cnt_q == 6'(bks_pkg::CordIter - 1)) state_d = bks_pkg::S_TLOAD;
      end
      bks_pkg::S_TLOAD: state_d = bks_pkg::S_TDIV;
      bks_pkg::S_TDIV: begin
        if (cnt_q == 6'(bks_pkg::DivSteps - 1)) state_d = bks_pkg::S_VTLO;
      end
      bks_pkg::S_VTLO:  state_d = bks_pkg::S_VTHI;
      bks_pkg::S_VTHI:  state_d = bks_pkg::S_QLOAD;
      bks_pkg::S_QLOAD: begin
        state_d = (numw[77:47] >= wb_eff[30:0]) ? bks_pkg::S_RLO : bks_pkg::S_QDIV;
      end
      bks_pkg::S_QDIV: begin
        if (cnt_q == 6'(bks_pkg::DivSteps - 1)) state_d = bks_pkg::S_RLO;
      end
      bks_pkg::S_RLO:   state_d = bks_pkg::S_RHI;
      bks_pkg::S_RHI:   state_d = bks_pkg::S_RSUM;
      bks_pkg::S_RSUM:  state_d = bks_pkg::S_KLO;
      bks_pkg::S_KLO:   state_d = bks_pkg::S_KHI;
      bks_pkg::S_KHI:   state_d = bks_pkg::S_TURN;
      bks_pkg::S_TURN:  state_d = bks_pkg::S_DONE;
      bks_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = bks_pkg::S_IDLE;
      end
      default:          state_d = bks_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bks_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      wb_q        <= 31'd163840;
      lim_q       <= 14'd6258;
      floor_q     <= 32'sd0;
      ceil_q      <= 32'sd655360;
      cur_x_q     <= 32'sd0;
      cur_y_q     <= 32'sd0;
      cur_hd_q    <= 16'd0;
      cur_spd_q   <= 32'sd0;
      cnt_q       <= 6'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (bks_pkg::reg_idx_e'(cfg_index_i))
          bks_pkg::REG_WHEELBASE: wb_q    <= cfg_data_i[30:0];
          bks_pkg::REG_STEER_LIM: lim_q   <= cfg_data_i[13:0];
          bks_pkg::REG_SPD_FLOOR: floor_q <= signed'(cfg_data_i);
          bks_pkg::REG_SPD_CEIL:  ceil_q  <= signed'(cfg_data_i);
          default:                wb_q    <= wb_q;
        endcase
      end
      if (state_q == bks_pkg::S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        bks_pkg::S_IDLE: begin
          if (in_valid_i && action_i == bks_pkg::ACT_LOAD) begin
            cur_x_q   <= signed'(load_x_i);
            cur_y_q   <= signed'(load_y_i);
            cur_hd_q  <= load_heading_i;
            cur_spd_q <= signed'(load_speed_i);
          end
          cnt_q <= 6'd0;
        end
        bks_pkg::S_CORD1, bks_pkg::S_CORD2, bks_pkg::S_TDIV, bks_pkg::S_QDIV: begin
          cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : 6'd0;
        end
        bks_pkg::S_MY1: cur_x_q <= psat;
        bks_pkg::S_ACC: cur_y_q <= psat;
        bks_pkg::S_TURN: begin
          cur_hd_q  <= cur_hd_q + (neg ? 16'(-turn) : turn);
          cur_spd_q <= nv_q;
        end
        default: cnt_q <= 6'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      bks_pkg::S_IDLE: begin
        accel_q <= signed'(accel_i);
        st_q    <= st_clamp;
        dt_q    <= time_step_i;
        cx_q    <= signed'(bks_pkg::CordGain);
        cy_q    <= 34'sd0;
        cz_q    <= 26'(ang_f) <<< 8;
        flip_q  <= ang_flip;
      end
      bks_pkg::S_CORD1, bks_pkg::S_CORD2: begin
        if (!cz_q[25]) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_s;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_s;
        end
      end
      bks_pkg::S_SPD: begin
        nv_q   <= nv34[31:0];
        cx_q   <= signed'(bks_pkg::CordGain);
        cy_q   <= 34'sd0;
        cz_q   <= 26'(ang_f) <<< 8;
        flip_q <= ang_flip;
      end
      bks_pkg::S_TLOAD: begin
        rem_q <= 32'd0;
        num_q <= {s_abs[30:0], 16'd0};
        div_q <= (c_val <= 34'sd0) ? 32'd1 : c_val[31:0];
      end
      bks_pkg::S_TDIV, bks_pkg::S_QDIV: begin
        rem_q <= rge ? 32'(rsh - {1'b0, div_q}) : rsh[31:0];
        num_q <= {num_q[45:0], rge};
      end
      bks_pkg::S_VTHI, bks_pkg::S_RHI, bks_pkg::S_KHI: acc_q <= prod_q[63:0];
      bks_pkg::S_QLOAD: begin
        rem_q <= {1'b0, numw[77:47]};
        div_q <= wb_eff;
        if (numw[77:47] >= wb_eff[30:0]) begin
          num_q <= '1;
        end else begin
          num_q <= numw[46:0];
        end
      end
      bks_pkg::S_RSUM: r_q <= acc_q[62:0] + {prod_q[30:0], 32'd0};
      bks_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          o_x_q   <= cur_x_q;
          o_y_q   <= cur_y_q;
          o_hd_q  <= cur_hd_q;
          o_spd_q <= cur_spd_q;
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

endmodule

[rtl/bks_chk.sv]
module bks_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pos_x_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("not busy after item accepted");

  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("item finished without result");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o))
    else $error("result appeared right after acceptance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pos_x_o)))
    else $error("stalled result changed");

endmodule

bind bicycle_kinematic_step_top bks_chk u_bks_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_o     (pos_x_o)
);

[tb/tb.sv]
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [31:0] accel_i;
  logic [15:0] steer_i;
  logic [15:0] time_step_i;
  logic [31:0] load_x_i;
  logic [31:0] load_y_i;
  logic [15:0] load_heading_i;
  logic [31:0] load_speed_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] pos_x_o;
  logic [31:0] pos_y_o;
  logic [15:0] heading_o;
  logic [31:0] speed_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hd;
    logic [31:0] spd;
  } pose_t;

  pose_t       pose_q[$];
  pose_t       pose;
  logic [30:0] wheelbase;
  logic [13:0] steer_lim;
  logic [31:0] spd_floor;
  logic [31:0] spd_ceil;
  int          send_idle_pct;
  int          stall_pct;
  int          idle_cycles;
  bit          failed;

  bicycle_kinematic_step_top dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'($signed(ang)) * 256;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > (64'sd1 << 22)) begin
      z -= (64'sd1 << 23);
      flip = 1;
    end else if (z < -(64'sd1 << 22)) begin
      z += (64'sd1 << 23);
      flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'(bks_pkg::atan_lut(i[4:0]));
      end else begin
        x += ys;
        y -= xs;
        z += longint'(bks_pkg::atan_lut(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void advance_pose(logic act, logic [31:0] acc, logic [15:0] st_in,
                                       logic [15:0] dt_in, logic [31:0] lx, logic [31:0] ly,
                                       logic [15:0] lh, logic [31:0] ls);
    longint st, dt, lim, v, px, py, c, s, sc, ss, t, tanm, nv, a;
    logic [63:0] wb, vm, q, r, rh, rl, turn;
    logic [127:0] wide;
    bit neg;
    if (act == bks_pkg::ACT_LOAD) begin
      pose = '{lx, ly, lh, ls};
      return;
    end
    a = longint'($signed(acc));
    st = longint'($signed(st_in));
    dt = longint'(dt_in);
    lim = longint'(steer_lim);
    v = longint'($signed(pose.spd));
    px = longint'($signed(pose.x));
    py = longint'($signed(pose.y));
    if (st > lim) st = lim;
    if (st < -lim) st = -lim;
    sin_cos(pose.hd, c, s);
    t = floor_sh(v * c, 30);
    px = sat_word(px + floor_sh(t * dt, 16));
    t = floor_sh(v * s, 30);
    py = sat_word(py + floor_sh(t * dt, 16));
    sin_cos(st[15:0], sc, ss);
    if (sc <= 0) sc = 1;
    tanm = ((ss < 0 ? -ss : ss) * 65536) / sc;
    wb = 64'(wheelbase);
    if (wb == 0) wb = 1;
    vm = v < 0 ? -v : v;
    wide = 128'(vm) * 128'(tanm);
    wide = wide / 128'(wb);
    q = (wide > 128'((64'd1 << 47) - 1)) ? (64'd1 << 47) - 1 : wide[63:0];
    r = q * 64'(dt);
    rh = r >> 32;
    rl = r & 64'hFFFF_FFFF;
    turn = ((rh * 64'd683565276 + ((rl * 64'd683565276) >> 32)) >> 16) & 64'hFFFF;
    neg = ((v < 0) != (st < 0)) && v != 0 && st != 0;
    if (neg) turn = (64'h10000 - turn) & 64'hFFFF;
    nv = v + floor_sh(a * dt, 16);
    if (nv < longint'($signed(spd_floor))) nv = longint'($signed(spd_floor));
    if (nv > longint'($signed(spd_ceil))) nv = longint'($signed(spd_ceil));
    pose.x = px[31:0];
    pose.y = py[31:0];
    pose.hd = pose.hd + turn[15:0];
    pose.spd = nv[31:0];
  endfunction

  task automatic send_item(logic act, logic [31:0] acc, logic [15:0] st, logic [15:0] dt,
                           logic [31:0] lx, logic [31:0] ly, logic [15:0] lh,
                           logic [31:0] ls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    accel_i <= acc;
    steer_i <= st;
    time_step_i <= dt;
    load_x_i <= lx;
    load_y_i <= ly;
    load_heading_i <= lh;
    load_speed_i <= ls;
    advance_pose(act, acc, st, dt, lx, ly, lh, ls);
    pose_q.push_back(pose);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_step(logic [31:0] acc, logic [15:0] st, logic [15:0] dt);
    send_item(bks_pkg::ACT_STEP, acc, st, dt, $urandom, $urandom, 16'($urandom), $urandom);
  endtask

  task automatic send_load(logic [31:0] lx, logic [31:0] ly, logic [15:0] lh,
                           logic [31:0] ls);
    send_item(bks_pkg::ACT_LOAD, $urandom, 16'($urandom), 16'($urandom), lx, ly, lh, ls);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(bks_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bks_pkg::REG_WHEELBASE: wheelbase = val[30:0];
      bks_pkg::REG_STEER_LIM: steer_lim = val[13:0];
      bks_pkg::REG_SPD_FLOOR: spd_floor = val;
      default:                spd_ceil = val;
    endcase
  endtask

  task automatic set_regs(logic [31:0] wb, logic [31:0] sl, logic [31:0] fl, logic [31:0] cl);
    drain();
    write_reg(bks_pkg::REG_WHEELBASE, wb);
    write_reg(bks_pkg::REG_STEER_LIM, sl);
    write_reg(bks_pkg::REG_SPD_FLOOR, fl);
    write_reg(bks_pkg::REG_SPD_CEIL, cl);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed;
    send_step(32'h0001_0000, 16'h0400, 16'hFFFF);
    send_step(32'h7FFF_FFFF, 16'h7FFF, 16'hFFFF);
    send_step(32'h8000_0000, 16'h8000, 16'hFFFF);
    send_step(32'h0002_0000, 16'h0000, 16'h0000);
    send_load(32'h7FFF_FF00, 32'h8000_0100, 16'h0000, 32'h7FFF_FFFF);
    send_step(32'h0, 16'h1000, 16'hFFFF);
    send_load(32'h8000_0100, 32'h7FFF_FF00, 16'h8000, 32'h8000_0000);
    send_step(32'h0, 16'hF000, 16'hFFFF);
    send_load(32'h0, 32'h0, 16'h7FFF, 32'h0005_0000);
    send_step(32'h0, 16'h1800, 16'h8000);
    send_load(32'h0, 32'h0, 16'h4000, 32'hFFFB_0000);
    send_step(32'hFFFF_0000, 16'h1800, 16'hFFFF);
    send_load(32'h0, 32'h0, 16'hC000, 32'h0003_0000);
    send_step(32'h0, 16'hE800, 16'h4000);
  endtask

  task automatic test_corner_regs;
    set_regs(32'h0000_0000, 32'd16000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_load(32'h0, 32'h0, 16'h0, 32'h7FFF_FFFF);
    send_step(32'h0, 16'h7FFF, 16'hFFFF);
    send_step(32'h7FFF_FFFF, 16'h8000, 16'hFFFF);
    send_step(32'h8000_0000, 16'h0, 16'hFFFF);
    set_regs(32'h7FFF_FFFF, 32'h0, 32'h0005_0000, 32'h0001_0000);
    send_step(32'h0001_0000, 16'h2000, 16'h8000);
    send_step(32'hFFFF_0000, 16'hE000, 16'h8000);
  endtask

  task automatic test_random(int n);
    logic [31:0] acc;
    logic [15:0] dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_load($urandom_range(1) ? $urandom : 32'($signed(16'($urandom))) <<< 8,
                  $urandom_range(1) ? $urandom : 32'($signed(16'($urandom))) <<< 8,
                  16'($urandom),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 32'hF_0000));
      end else begin
        acc = $urandom_range(3) == 0 ? $urandom : 32'($signed(20'($urandom)));
        dt = 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 16'h1000));
        send_step(acc, 16'($urandom), dt);
      end
    end
  endtask

  task automatic test_random_regs(int n);
    set_regs($urandom_range(1) ? $urandom : $urandom_range(1, 32'h8_0000),
             $urandom_range(0, 16000), 32'hFFFF_0000 - ($urandom & 32'hF_FFFF),
             $urandom_range(0, 32'h10_0000));
    test_random(n);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    accel_i = '0;
    steer_i = '0;
    time_step_i = '0;
    load_x_i = '0;
    load_y_i = '0;
    load_heading_i = '0;
    load_speed_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = bks_pkg::REG_WHEELBASE;
    cfg_data_i = '0;
    wheelbase = 31'd163840;
    steer_lim = 14'd6258;
    spd_floor = 32'd0;
    spd_ceil = 32'd655360;
    pose = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    failed = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_corner_regs();
    test_random_regs(450);
    send_idle_pct = 86;
    test_random_regs(450);
    send_idle_pct = 0;
    stall_pct = 86;
    test_random_regs(450);
    send_idle_pct = 32;
    stall_pct = 32;
    test_random_regs(450);
    drain();
    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    pose_t exp_pose;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pose_q.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h hd=%h v=%h", $time, pos_x_o, pos_y_o,
                 heading_o, speed_o);
        failed = 1;
      end else begin
        exp_pose = pose_q.pop_front();
        if (pos_x_o !== exp_pose.x) begin
          $display("%0t pos_x exp %h got %h", $time, exp_pose.x, pos_x_o);
          failed = 1;
        end
        if (pos_y_o !== exp_pose.y) begin
          $display("%0t pos_y exp %h got %h", $time, exp_pose.y, pos_y_o);
          failed = 1;
        end
        if (heading_o !== exp_pose.hd) begin
          $display("%0t heading exp %h got %h", $time, exp_pose.hd, heading_o);
          failed = 1;
        end
        if (speed_o !== exp_pose.spd) begin
          $display("%0t speed exp %h got %h", $time, exp_pose.spd, speed_o);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || pose_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
